// ----- src/arith_expression_tokenizer_defines.svh -----
// Assertion macros used by the tokenizer back end
`ifndef ARITH_EXPRESSION_TOKENIZER_DEFINES_SVH
`define ARITH_EXPRESSION_TOKENIZER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define AET_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("aet check failed");

// next-cycle implication, disabled while reset is asserted
`define AET_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("aet check failed");

`endif

// ----- src/aet_pkg.sv -----
// Types and constants shared by the tokenizer modules
package aet_pkg;

    typedef enum logic [3:0] {
        TK_NUMBER = 4'd0,
        TK_SPACE  = 4'd1,
        TK_PLUS   = 4'd2,
        TK_MINUS  = 4'd3,
        TK_STAR   = 4'd4,
        TK_SLASH  = 4'd5,
        TK_OPEN   = 4'd6,
        TK_CLOSE  = 4'd7,
        TK_BAD    = 4'd8,
        TK_END    = 4'd9
    } token_kind_t;

    typedef enum logic [1:0] {
        RUN_NONE  = 2'd0,
        RUN_NUM   = 2'd1,
        RUN_SPACE = 2'd2
    } run_kind_t;

    typedef enum logic [1:0] {
        CLS_END   = 2'd0,
        CLS_DIGIT = 2'd1,
        CLS_SPACE = 2'd2,
        CLS_TOKEN = 2'd3
    } byte_class_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    typedef struct packed {
        byte_class_t cls;
        token_kind_t kind;
        logic [3:0]  digit;
        logic [7:0]  bad_byte;
    } fe_item_t;

    typedef struct packed {
        token_kind_t kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [63:0] value;
        logic        error;
        logic [7:0]  bad_byte;
        logic        last;
    } result_t;

endpackage

// ----- src/arith_expression_tokenizer.sv -----
// A byte's first token beat is registered in the queue, then in the output register.
// Throughput: one byte per cycle while the output is not stalled; a byte that closes a
// run and makes its own token yields two beats (output register, hold slot) and stalls
// the run tracker until the hold slot drains; the value*10+digit step is combinational.
// Reset: aresetn (synchronous, active low) clears run state, position and the queue.
// Top level: arithmetic expression tokenizer
module arith_expression_tokenizer #(
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_byte,
    input  logic        s_end_marker,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_token_kind,
    output logic [15:0] m_token_start,
    output logic [15:0] m_token_length,
    output logic [63:0] m_number_value,
    output logic        m_error_flag,
    output logic [7:0]  m_bad_byte,
    output logic        m_last_result
);
    import aet_pkg::*;

    localparam int ITEM_W = $bits(fe_item_t);

    logic              q_ready, q_push, q_valid, q_pop;
    fe_item_t          push_item, head_item;
    logic [ITEM_W-1:0] head_data;
    result_t           res;

    aet_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_byte  (s_char_byte),
        .s_end_marker (s_end_marker),
        .q_ready      (q_ready),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    aet_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (2)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_push   (q_push),
        .in_data   (push_item),
        .in_ready  (q_ready),
        .out_pop   (q_pop),
        .out_data  (head_data),
        .out_valid (q_valid)
    );

    assign head_item = fe_item_t'(head_data);

    aet_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (res)
    );

    assign m_token_kind   = res.kind;
    assign m_token_start  = res.start;
    assign m_token_length = res.length;
    assign m_number_value = res.value;
    assign m_error_flag   = res.error;
    assign m_bad_byte     = res.bad_byte;
    assign m_last_result  = res.last;

endmodule

// ----- src/aet_front.sv -----
// Front end: accepts source bytes and classifies them
module aet_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_char_byte,
    input  logic              s_end_marker,
    input  logic              q_ready,
    output logic              q_push,
    output aet_pkg::fe_item_t q_item
);
    import aet_pkg::*;

    logic [7:0] digit_diff;

    assign s_ready    = q_ready;
    assign q_push     = s_valid && q_ready;
    assign digit_diff = s_char_byte - CH_ZERO;

    always_comb begin
        q_item.cls      = CLS_TOKEN;
        q_item.kind     = TK_BAD;
        q_item.digit    = digit_diff[3:0];
        q_item.bad_byte = 8'd0;
        if (s_end_marker || s_char_byte == CH_NUL) begin
            q_item.cls = CLS_END;
            q_item.kind = TK_END;
        end else if (s_char_byte >= CH_ZERO && s_char_byte <= CH_NINE) begin
            q_item.cls = CLS_DIGIT;
            q_item.kind = TK_NUMBER;
        end else if (s_char_byte == CH_SPACE ||
                     (s_char_byte >= CH_TAB && s_char_byte <= CH_CR)) begin
            q_item.cls = CLS_SPACE;
            q_item.kind = TK_SPACE;
        end else begin
            case (s_char_byte)
                CH_PLUS:  q_item.kind = TK_PLUS;
                CH_MINUS: q_item.kind = TK_MINUS;
                CH_STAR:  q_item.kind = TK_STAR;
                CH_SLASH: q_item.kind = TK_SLASH;
                CH_OPEN:  q_item.kind = TK_OPEN;
                CH_CLOSE: q_item.kind = TK_CLOSE;
                default: begin
                    q_item.kind     = TK_BAD;
                    q_item.bad_byte = s_char_byte;
                end
            endcase
        end
    end

endmodule

// ----- src/aet_queue.sv -----
// Small flop-based queue between classifier and run tracker
module aet_queue #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_push,
    input  logic [WIDTH-1:0] in_data,
    output logic             in_ready,
    input  logic             out_pop,
    output logic [WIDTH-1:0] out_data,
    output logic             out_valid
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (out_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (in_push && !out_pop) begin
            count_next = count_reg + 1'b1;
        end else if (out_pop && !in_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ----- src/aet_back.sv -----
// Back end: run tracking, number accumulation and token output
`include "arith_expression_tokenizer_defines.svh"

module aet_back #(
    parameter int POSITION_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  aet_pkg::fe_item_t q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output aet_pkg::result_t  out_res
);
    import aet_pkg::*;

    localparam int SW = (POSITION_BITS > 16) ? POSITION_BITS : 16;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    run_kind_t                run_kind_reg, run_kind_next;
    logic [POSITION_BITS-1:0] run_start_reg, run_start_next;
    logic [15:0]              run_length_reg, run_length_next;
    logic [63:0]              run_value_reg, run_value_next;
    logic                     run_ovf_reg, run_ovf_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     out_valid_reg, out_valid_next;
    result_t                  out_reg, out_next;
    logic                     hold_valid_reg, hold_valid_next;
    result_t                  hold_reg, hold_next;

    logic [63:0]              base_value;
    logic [67:0]              acc;
    logic                     acc_ovf;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [15:0]              len_inc;
    logic                     has_run, flush_now, emit_flush, emit_own, out_free;
    result_t                  flush_res, own_res, r_first, r_second;
    logic [1:0]               n_res;

    function automatic logic [15:0] sat_pos(input logic [POSITION_BITS-1:0] p);
        logic [SW-1:0] e;
        e = SW'(p);
        return (e > SW'(LEN_MAX)) ? LEN_MAX : e[15:0];
    endfunction

    assign out_free   = !out_valid_reg || out_ready;
    assign q_pop      = q_valid && !hold_valid_reg && out_free;
    assign out_valid  = out_valid_reg;
    assign out_res    = out_reg;

    // value*10 + digit, top nibble flags overflow
    assign base_value = (run_kind_reg == RUN_NUM) ? run_value_reg : 64'd0;
    assign acc        = 68'({base_value, 3'b000}) + 68'({base_value, 1'b0})
                      + 68'(q_item.digit);
    assign acc_ovf    = |acc[67:64];
    assign pos_inc    = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign len_inc    = (run_length_reg == LEN_MAX) ? run_length_reg
                                                    : run_length_reg + 1'b1;
    assign has_run    = (run_kind_reg != RUN_NONE);

    always_comb begin
        case (q_item.cls)
            CLS_END:   flush_now = 1'b1;
            CLS_DIGIT: flush_now = (run_kind_reg != RUN_NUM);
            CLS_SPACE: flush_now = (run_kind_reg != RUN_SPACE);
            CLS_TOKEN: flush_now = 1'b1;
            default:   flush_now = 1'b1;
        endcase
        emit_flush = flush_now && has_run;
        emit_own   = (q_item.cls == CLS_END) || (q_item.cls == CLS_TOKEN);
        n_res      = {1'b0, emit_flush} + {1'b0, emit_own};

        flush_res.kind     = (run_kind_reg == RUN_NUM) ? TK_NUMBER : TK_SPACE;
        flush_res.start    = sat_pos(run_start_reg);
        flush_res.length   = run_length_reg;
        flush_res.value    = (run_kind_reg == RUN_NUM) ? run_value_reg : 64'd0;
        flush_res.error    = (run_kind_reg == RUN_NUM) && run_ovf_reg;
        flush_res.bad_byte = 8'd0;
        flush_res.last     = !emit_own;

        own_res.kind     = q_item.kind;
        own_res.start    = sat_pos(pos_reg);
        own_res.length   = (q_item.cls == CLS_END) ? 16'd0 : 16'd1;
        own_res.value    = 64'd0;
        own_res.error    = (q_item.cls == CLS_TOKEN) && (q_item.kind == TK_BAD);
        own_res.bad_byte = q_item.bad_byte;
        own_res.last     = 1'b1;

        r_first  = emit_flush ? flush_res : own_res;
        r_second = own_res;
    end

    always_comb begin
        run_kind_next   = run_kind_reg;
        run_start_next  = run_start_reg;
        run_length_next = run_length_reg;
        run_value_next  = run_value_reg;
        run_ovf_next    = run_ovf_reg;
        pos_next        = pos_reg;
        if (q_pop) begin
            case (q_item.cls)
                CLS_END: begin
                    run_kind_next   = RUN_NONE;
                    run_start_next  = '0;
                    run_length_next = '0;
                    run_value_next  = '0;
                    run_ovf_next    = 1'b0;
                    pos_next        = '0;
                end
                CLS_DIGIT: begin
                    if (run_kind_reg != RUN_NUM) begin
                        run_kind_next   = RUN_NUM;
                        run_start_next  = pos_reg;
                        run_length_next = 16'd1;
                        run_ovf_next    = acc_ovf;
                    end else begin
                        run_length_next = len_inc;
                        run_ovf_next    = run_ovf_reg || acc_ovf;
                    end
                    run_value_next = acc_ovf ? '1 : acc[63:0];
                    pos_next       = pos_inc;
                end
                CLS_SPACE: begin
                    if (run_kind_reg != RUN_SPACE) begin
                        run_kind_next   = RUN_SPACE;
                        run_start_next  = pos_reg;
                        run_length_next = 16'd1;
                        run_value_next  = '0;
                        run_ovf_next    = 1'b0;
                    end else begin
                        run_length_next = len_inc;
                    end
                    pos_next = pos_inc;
                end
                default: begin
                    run_kind_next   = RUN_NONE;
                    run_start_next  = '0;
                    run_length_next = '0;
                    run_value_next  = '0;
                    run_ovf_next    = 1'b0;
                    pos_next        = pos_inc;
                end
            endcase
        end
    end

    // output register plus one holding slot for the second beat of a pair
    always_comb begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (hold_valid_reg && out_free) begin
            out_next        = hold_reg;
            out_valid_next  = 1'b1;
            hold_valid_next = 1'b0;
        end else if (q_pop && n_res != 2'd0) begin
            out_next        = r_first;
            out_valid_next  = 1'b1;
            hold_next       = r_second;
            hold_valid_next = (n_res == 2'd2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_kind_reg   <= RUN_NONE;
            run_start_reg  <= '0;
            run_length_reg <= '0;
            run_value_reg  <= '0;
            run_ovf_reg    <= 1'b0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            run_kind_reg   <= run_kind_next;
            run_start_reg  <= run_start_next;
            run_length_reg <= run_length_next;
            run_value_reg  <= run_value_next;
            run_ovf_reg    <= run_ovf_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    `AET_ASSERT_IMPL(a_hold_needs_out, aclk, aresetn, hold_valid_reg, out_valid_reg)
    `AET_ASSERT_IMPL(a_pair_order, aclk, aresetn, hold_valid_reg, !out_reg.last && hold_reg.last)
    `AET_ASSERT_NEXT(a_end_clears_pos, aclk, aresetn, q_pop && q_item.cls == CLS_END, pos_reg == '0)
    `AET_ASSERT_IMPL(a_idle_run_empty, aclk, aresetn, run_kind_reg == RUN_NONE, run_length_reg == '0)

endmodule

// ----- verif/tb_arith_expression_tokenizer.sv -----
// Testbench for arith_expression_tokenizer: byte stimulus, token prediction and beat checks
`timescale 1ns / 1ps

module tb_arith_expression_tokenizer;
    import aet_pkg::*;

    localparam int POSITION_BITS = 16;
    localparam longint unsigned POS_MAX = (64'd1 << POSITION_BITS) - 1;
    localparam int QUIET_LIMIT = 2000;
    localparam logic [7:0] OP_BYTES [6] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                            CH_OPEN, CH_CLOSE};

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_char_byte;
    logic        s_end_marker;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_token_kind;
    logic [15:0] m_token_start;
    logic [15:0] m_token_length;
    logic [63:0] m_number_value;
    logic        m_error_flag;
    logic [7:0]  m_bad_byte;
    logic        m_last_result;

    arith_expression_tokenizer #(
        .POSITION_BITS(POSITION_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_byte    (s_char_byte),
        .s_end_marker   (s_end_marker),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_token_start  (m_token_start),
        .m_token_length (m_token_length),
        .m_number_value (m_number_value),
        .m_error_flag   (m_error_flag),
        .m_bad_byte     (m_bad_byte),
        .m_last_result  (m_last_result)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // tokenizer state mirror
    run_kind_t       run_kind  = RUN_NONE;
    longint unsigned run_start = 0;
    longint unsigned run_len   = 0;
    logic [63:0]     run_value = '0;
    logic            run_ovf   = 1'b0;
    longint unsigned byte_pos  = 0;

    result_t pending_tokens [$];
    result_t step_tokens [$];

    int  mismatch_count = 0;
    int  beat_count     = 0;
    int  bytes_sent     = 0;
    int  quiet_cycles   = 0;
    int  stall_cnt      = 0;
    bit  idle_on        = 1'b1;

    function automatic logic [15:0] clamp16(input longint unsigned v);
        return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic result_t make_token(input token_kind_t kind, input longint unsigned start,
                                           input longint unsigned len, input logic [63:0] value,
                                           input logic err, input logic [7:0] bad);
        result_t t;
        t        = '0;
        t.kind   = kind;
        t.start  = clamp16(start);
        t.length = clamp16(len);
        t.value  = value;
        t.error  = err;
        t.bad_byte = bad;
        return t;
    endfunction

    task automatic close_run();
        if (run_kind == RUN_NUM) begin
            step_tokens.push_back(make_token(TK_NUMBER, run_start, run_len, run_value, run_ovf,
                                             8'h00));
        end else if (run_kind == RUN_SPACE) begin
            step_tokens.push_back(make_token(TK_SPACE, run_start, run_len, '0, 1'b0, 8'h00));
        end
        run_kind  = RUN_NONE;
        run_start = 0;
        run_len   = 0;
        run_value = '0;
        run_ovf   = 1'b0;
    endtask

    task automatic enter_run(input run_kind_t kind);
        if (run_kind != kind) begin
            close_run();
            run_kind  = kind;
            run_start = byte_pos;
            run_len   = 1;
        end else if (run_len < 64'hFFFF) begin
            run_len++;
        end
    endtask

    task automatic tokenize_byte(input logic [7:0] b, input logic e);
        logic [63:0] d;
        token_kind_t kind;
        step_tokens.delete();
        if (e || b == CH_NUL) begin
            close_run();
            step_tokens.push_back(make_token(TK_END, byte_pos, 0, '0, 1'b0, 8'h00));
            byte_pos = 0;
        end else begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
                d = 64'(b - CH_ZERO);
                enter_run(RUN_NUM);
                if (run_value > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
                    run_value = '1;
                    run_ovf   = 1'b1;
                end else begin
                    run_value = run_value * 64'd10 + d;
                end
            end else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
                enter_run(RUN_SPACE);
            end else begin
                close_run();
                case (b)
                    CH_PLUS:  kind = TK_PLUS;
                    CH_MINUS: kind = TK_MINUS;
                    CH_STAR:  kind = TK_STAR;
                    CH_SLASH: kind = TK_SLASH;
                    CH_OPEN:  kind = TK_OPEN;
                    CH_CLOSE: kind = TK_CLOSE;
                    default:  kind = TK_BAD;
                endcase
                if (kind == TK_BAD) begin
                    step_tokens.push_back(make_token(TK_BAD, byte_pos, 1, '0, 1'b1, b));
                end else begin
                    step_tokens.push_back(make_token(kind, byte_pos, 1, '0, 1'b0, 8'h00));
                end
            end
            if (byte_pos < POS_MAX) begin
                byte_pos++;
            end
        end
        if (step_tokens.size() > 0) begin
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        end
        foreach (step_tokens[i]) begin
            pending_tokens.push_back(step_tokens[i]);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic e);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_char_byte  <= b;
        s_end_marker <= e;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tokenize_byte(b, e);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_tokens.size() != 0) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < 100) begin
            $display("beat %0d: %s got %0h want %0h", beat_count, what, got, want);
        end
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            m_ready   <= (stall_cnt == 1);
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_cnt <= $urandom_range(1, 11);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_beats
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_tokens.size() == 0) begin
                report_mismatch("unexpected beat, kind", 64'(m_token_kind), '0);
            end else begin
                want = pending_tokens.pop_front();
                if (m_token_kind !== want.kind)
                    report_mismatch("token_kind", 64'(m_token_kind), 64'(want.kind));
                if (m_token_start !== want.start)
                    report_mismatch("token_start", 64'(m_token_start), 64'(want.start));
                if (m_token_length !== want.length)
                    report_mismatch("token_length", 64'(m_token_length), 64'(want.length));
                if (m_number_value !== want.value)
                    report_mismatch("number_value", m_number_value, want.value);
                if (m_error_flag !== want.error)
                    report_mismatch("error_flag", 64'(m_error_flag), 64'(want.error));
                if (m_bad_byte !== want.bad_byte)
                    report_mismatch("bad_byte", 64'(m_bad_byte), 64'(want.bad_byte));
                if (m_last_result !== want.last)
                    report_mismatch("last_result", 64'(m_last_result), 64'(want.last));
            end
            beat_count++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // operators, whitespace class edges, bad bytes, zero byte and end marker
    task automatic test_directed_tokens();
        logic [8:0] seq [27] = '{
            {1'b0, CH_ZERO}, {1'b0, CH_NINE}, {1'b0, CH_PLUS}, {1'b0, CH_TAB},
            {1'b0, CH_SPACE}, {1'b0, CH_CR}, {1'b0, CH_MINUS}, {1'b0, CH_OPEN},
            {1'b0, CH_STAR}, {1'b0, CH_CLOSE}, {1'b0, CH_SLASH}, 9'h001, 9'h0FF,
            9'h080, 9'h035, 9'h00B, {1'b0, CH_NUL}, 9'h037, 9'h133, 9'h1FF,
            9'h00A, 9'h00C, 9'h07F, 9'h008, 9'h00E, 9'h02E, 9'h100
        };
        foreach (seq[i]) begin
            send_byte(seq[i][7:0], seq[i][8]);
        end
    endtask

    task automatic test_number_overflow();
        string exprs [4] = '{
            "18446744073709551615 18446744073709551616",
            "99999999999999999999999*0000000000000000000000001844674407370955161",
            "(18446744073709551620)",
            "1844674407370955161 5"
        };
        foreach (exprs[i]) begin
            for (int j = 0; j < exprs[i].len(); j++) begin
                send_byte(exprs[i][j], 1'b0);
            end
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // long mixed whitespace run closed by a number, an operator, a bad byte and a zero byte
    task automatic test_long_space_run();
        int pick;
        idle_on = 1'b0;
        repeat (40) begin
            pick = $urandom_range(0, 5);
            send_byte((pick == 5) ? CH_SPACE : CH_TAB + 8'(pick), 1'b0);
        end
        send_byte(8'h37, 1'b0);
        send_byte(8'h31, 1'b0);
        send_byte(CH_PLUS, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(CH_NUL, 1'b0);
        idle_on = 1'b1;
    endtask

    task automatic send_random_element();
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 5);
            repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        end else if (sel < 55) begin
            repeat ($urandom_range(1, 3)) begin
                n = $urandom_range(0, 5);
                send_byte((n == 5) ? CH_SPACE : CH_TAB + 8'(n), 1'b0);
            end
        end else if (sel < 85) begin
            send_byte(OP_BYTES[$urandom_range(0, 5)], 1'b0);
        end else if (sel < 93) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (sel < 97) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            send_byte(CH_NUL, 1'b0);
        end
    endtask

    task automatic test_random_expressions(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            send_random_element();
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_char_byte  = 8'h00;
        s_end_marker = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_tokens();
        test_number_overflow();
        wait_drained();
        test_long_space_run();
        test_random_expressions(400);
        wait_drained();
        test_random_expressions(400);
        idle_on = 1'b0;
        test_random_expressions(150);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/aet_pkg.sv
src/aet_front.sv
src/aet_queue.sv
src/aet_back.sv
src/arith_expression_tokenizer.sv
verif/tb_arith_expression_tokenizer.sv
